// ===== rtl/sped_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sped_pkg: shared definitions for the surround peak direction estimator
// Widths, fixed-point constants, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package sped_pkg;

    // Averaging window; must be a power of two.
    localparam int WINDOW_LEN = 8;
    localparam int WIN_BITS   = $clog2(WINDOW_LEN);

    localparam int LEVEL_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int CNT_W    = 4;
    localparam int THR_W    = 15;
    localparam int UNIT_W   = 16;
    localparam int SUM_W    = WIN_BITS + 17;
    localparam int MAG_W    = 15;
    localparam int ANG_W    = 16;
    localparam int MIX_W    = 34;
    localparam int PROD_W   = 50;
    localparam int ABS_W    = 49;
    localparam int QUO_W    = 15;
    localparam int SQ_W     = 30;
    localparam int CORDIC_W = 36;
    localparam int ACC_W    = 32;
    localparam int STEP_W   = 4;
    localparam int CFG_W    = 16;

    localparam logic [QUO_W-1:0] UNIT_ONE    = 15'd16384;
    localparam logic [13:0]      REAR_WEIGHT = 14'd11469;
    localparam int               MIX_SHIFT   = 23;
    localparam int               UNIT_SHIFT  = 14;
    localparam logic [ABS_W-1:0] BIG_LIMIT   = ABS_W'(64'd1 << 37);

    // Channel layout thresholds on channel_count.
    localparam logic [CNT_W-1:0] LAYOUT_STEREO = 4'd2;
    localparam logic [CNT_W-1:0] LAYOUT_5_1    = 4'd6;
    localparam logic [CNT_W-1:0] LAYOUT_7_1    = 4'd8;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 4'd2;
    localparam logic [THR_W-1:0]  THR_RESET   = 15'd1638;

    typedef enum logic [1:0] {
        CFG_GAIN      = 2'd0,
        CFG_COUNT     = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_index_t;

    // Arctangent of 2^-i as a fraction of a full turn (2^32).
    function automatic logic [ACC_W-1:0] turn_angle(input logic [STEP_W-1:0] i);
        logic [ACC_W-1:0] a;
        case (i)
            4'd0:    a = 32'h20000000;
            4'd1:    a = 32'h12E4051D;
            4'd2:    a = 32'h09FB385B;
            4'd3:    a = 32'h051111D4;
            4'd4:    a = 32'h028B0D43;
            4'd5:    a = 32'h0145D7E1;
            4'd6:    a = 32'h00A2F61E;
            4'd7:    a = 32'h00517C55;
            4'd8:    a = 32'h0028BE53;
            4'd9:    a = 32'h00145F2E;
            4'd10:   a = 32'h000A2F98;
            4'd11:   a = 32'h000517CC;
            4'd12:   a = 32'h00028BE6;
            4'd13:   a = 32'h000145F3;
            4'd14:   a = 32'h0000A2F9;
            default: a = 32'h0000517C;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/sped_polar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sped_polar: magnitude and bearing of the averaged direction vector
// Squares the components, then runs a bit-pair square root and a 16-step
// CORDIC vectoring loop side by side, one step per cycle.
// ----------------------------------------------------------------------------
module sped_polar
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sped_pkg::UNIT_W-1:0]  avg_x,
    input  logic signed [sped_pkg::UNIT_W-1:0]  avg_y,
    output logic                                done,
    output logic [sped_pkg::MAG_W-1:0]          magnitude,
    output logic [sped_pkg::ANG_W-1:0]          bearing
);

    typedef enum logic [2:0] {P_IDLE, P_SQA, P_SQB, P_ITER, P_OUT} pstate_t;

    pstate_t                                  state_reg;
    logic signed [sped_pkg::UNIT_W-1:0]       x_reg, y_reg;
    logic [sped_pkg::SQ_W-1:0]                sq_reg;
    logic [sped_pkg::MAG_W+3:0]               rem_reg;
    logic [sped_pkg::MAG_W-1:0]               root_reg;
    logic signed [sped_pkg::CORDIC_W-1:0]     u_reg, v_reg;
    logic [sped_pkg::ACC_W-1:0]               acc_reg;
    logic                                     zero_reg;
    logic [sped_pkg::STEP_W-1:0]              iter_reg;
    logic                                     done_reg;
    logic [sped_pkg::MAG_W-1:0]               mag_reg;
    logic [sped_pkg::ANG_W-1:0]               bearing_reg;

    logic signed [31:0]                       prod;
    logic signed [sped_pkg::CORDIC_W-1:0]     u_init, v_init, du, dv;
    logic [sped_pkg::MAG_W+3:0]               rem_shift, trial;
    logic [sped_pkg::ACC_W-1:0]               rounded;

    // One squarer, shared between the two components.
    always_comb
    begin
        prod = (state_reg == P_SQA) ? x_reg * x_reg : y_reg * y_reg;
    end

    // Start vector, the rear half turned by half a revolution.
    always_comb
    begin
        u_init = sped_pkg::CORDIC_W'(avg_y) <<< 16;
        v_init = sped_pkg::CORDIC_W'(avg_x) <<< 16;
        if (avg_y[sped_pkg::UNIT_W-1])
        begin
            u_init = -u_init;
            v_init = -v_init;
        end
    end

    // Step terms for the square root and the CORDIC rotation.
    always_comb
    begin
        rem_shift = {rem_reg[sped_pkg::MAG_W+1:0], sq_reg[sped_pkg::SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        du        = v_reg >>> iter_reg;
        dv        = u_reg >>> iter_reg;
        rounded   = acc_reg + 32'h0000_8000;
    end

    // Sequencer and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= P_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            sq_reg      <= '0;
            rem_reg     <= '0;
            root_reg    <= '0;
            u_reg       <= '0;
            v_reg       <= '0;
            acc_reg     <= '0;
            zero_reg    <= 1'b0;
            iter_reg    <= '0;
            done_reg    <= 1'b0;
            mag_reg     <= '0;
            bearing_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == P_OUT);
            case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= avg_x;
                        y_reg     <= avg_y;
                        u_reg     <= u_init;
                        v_reg     <= v_init;
                        acc_reg   <= avg_y[sped_pkg::UNIT_W-1] ? 32'h8000_0000 : '0;
                        zero_reg  <= (avg_x == '0) && (avg_y == '0);
                        state_reg <= P_SQA;
                    end
                end
                P_SQA:
                begin
                    sq_reg    <= sped_pkg::SQ_W'(prod);
                    state_reg <= P_SQB;
                end
                P_SQB:
                begin
                    sq_reg    <= sq_reg + sped_pkg::SQ_W'(prod);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= '0;
                    state_reg <= P_ITER;
                end
                P_ITER:
                begin
                    // Square root: one result bit per step, fifteen steps.
                    if (iter_reg != 4'd15)
                    begin
                        sq_reg <= sq_reg << 2;
                        if (rem_shift >= trial)
                        begin
                            rem_reg  <= rem_shift - trial;
                            root_reg <= {root_reg[sped_pkg::MAG_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_shift;
                            root_reg <= {root_reg[sped_pkg::MAG_W-2:0], 1'b0};
                        end
                    end
                    // CORDIC: rotate toward the positive u axis.
                    if (v_reg > 0)
                    begin
                        u_reg   <= u_reg + du;
                        v_reg   <= v_reg - dv;
                        acc_reg <= acc_reg + sped_pkg::turn_angle(iter_reg);
                    end
                    else
                    begin
                        u_reg   <= u_reg - du;
                        v_reg   <= v_reg + dv;
                        acc_reg <= acc_reg - sped_pkg::turn_angle(iter_reg);
                    end
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15)
                    begin
                        state_reg <= P_OUT;
                    end
                end
                P_OUT:
                begin
                    mag_reg     <= root_reg;
                    bearing_reg <= zero_reg ? '0 : rounded[31:16];
                    state_reg   <= P_IDLE;
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign magnitude = mag_reg;
    assign bearing   = bearing_reg;

endmodule

// ===== rtl/surround_peak_direction_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surround_peak_direction_estimator_core: sound direction from peak levels
// Mixes the layout's channel peak levels into a direction vector, averages
// it over a window and reports it with magnitude, bearing and a threshold flag.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel: in_valid/in_stall with six peak levels. A transaction is
//   taken only while the core is idle; in_stall is high while an item works.
// - Output channel: out_valid/out_stall with one result per input item.
// - One item is in work at a time; the next input is taken once the result
//   is registered and the core is back in idle. Each item runs through the
//   mix, the 16-step serial gain multiply, the 15-step normalizing divider
//   (only when division is needed), the ring update, the average and the
//   16-step polar loop.
// - A finished result sits in the output register; the core takes the next
//   input while it waits, and holds the following result until it is taken.
// - Reset clears the averaging ring, the sums and the slot pointer, and sets
//   the registers to gain 1.0, stereo and threshold 1638.
// - Configuration writes through cfg_we/cfg_index/cfg_data land at once and
//   are meant for idle periods; an unknown index is ignored.
// ----------------------------------------------------------------------------
module surround_peak_direction_estimator_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [sped_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sped_pkg::LEVEL_W-1:0]        front_left,
    input  logic [sped_pkg::LEVEL_W-1:0]        front_right,
    input  logic [sped_pkg::LEVEL_W-1:0]        rear_left,
    input  logic [sped_pkg::LEVEL_W-1:0]        rear_right,
    input  logic [sped_pkg::LEVEL_W-1:0]        side_left,
    input  logic [sped_pkg::LEVEL_W-1:0]        side_right,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sped_pkg::UNIT_W-1:0]  avg_x,
    output logic signed [sped_pkg::UNIT_W-1:0]  avg_y,
    output logic [sped_pkg::MAG_W-1:0]          magnitude,
    output logic [sped_pkg::ANG_W-1:0]          bearing,
    output logic                                above_threshold
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MIX, ST_MUL, ST_NORM, ST_DIV, ST_RING, ST_AVG, ST_POLAR, ST_DONE
    } state_t;

    state_t                                   state_reg;
    logic [sped_pkg::GAIN_W-1:0]              gain_reg;
    logic [sped_pkg::CNT_W-1:0]               count_reg;
    logic [sped_pkg::THR_W-1:0]               thr_reg;
    logic [sped_pkg::LEVEL_W-1:0]             fl_reg, fr_reg, rl_reg, rr_reg, sl_reg, sr_reg;
    logic signed [sped_pkg::MIX_W-1:0]        d_reg;
    logic signed [31:0]                       e_reg;
    logic signed [sped_pkg::PROD_W-1:0]       x_acc_reg, y_acc_reg;
    logic [sped_pkg::STEP_W-1:0]              step_reg;
    logic [sped_pkg::ABS_W-1:0]               abs_x_reg, abs_y_reg, max_reg;
    logic                                     big_reg, neg_x_reg, neg_y_reg;
    logic [sped_pkg::ABS_W:0]                 rem_x_reg, rem_y_reg;
    logic [sped_pkg::QUO_W-1:0]               q_x_reg, q_y_reg;
    logic signed [sped_pkg::UNIT_W-1:0]       ring_x_reg [sped_pkg::WINDOW_LEN];
    logic signed [sped_pkg::UNIT_W-1:0]       ring_y_reg [sped_pkg::WINDOW_LEN];
    logic signed [sped_pkg::SUM_W-1:0]        sum_x_reg, sum_y_reg;
    logic [sped_pkg::WIN_BITS-1:0]            slot_reg;
    logic signed [sped_pkg::UNIT_W-1:0]       avg_x_reg, avg_y_reg;
    logic                                     start_reg;
    logic                                     out_valid_reg;
    logic signed [sped_pkg::UNIT_W-1:0]       out_x_reg, out_y_reg;
    logic [sped_pkg::MAG_W-1:0]               out_mag_reg;
    logic [sped_pkg::ANG_W-1:0]               out_bearing_reg;
    logic                                     out_above_reg;

    logic signed [16:0]                       diff_front, diff_rear, diff_side;
    logic signed [17:0]                       diff_fb;
    logic signed [31:0]                       rear_prod;
    logic signed [sped_pkg::MIX_W-1:0]        mix_d;
    logic signed [31:0]                       mix_e;
    logic signed [sped_pkg::PROD_W-1:0]       x_acc_next, y_acc_next;
    logic [sped_pkg::ABS_W-1:0]               abs_x, abs_y;
    logic [sped_pkg::ABS_W:0]                 shift_x, shift_y;
    logic                                     ge_x, ge_y;
    logic [sped_pkg::ABS_W-1:0]               small_x, small_y;
    logic [sped_pkg::QUO_W-1:0]               unit_x, unit_y;
    logic signed [sped_pkg::UNIT_W-1:0]       nx, ny;
    logic signed [sped_pkg::SUM_W-1:0]        sum_x_next, sum_y_next;
    logic signed [sped_pkg::SUM_W-1:0]        bias_x, bias_y;
    logic                                     polar_done;
    logic [sped_pkg::MAG_W-1:0]               polar_mag;
    logic [sped_pkg::ANG_W-1:0]               polar_bearing;
    logic                                     out_free;

    // Channel differences and the layout-dependent mix before gain.
    always_comb
    begin
        diff_front = $signed({1'b0, fr_reg}) - $signed({1'b0, fl_reg});
        diff_rear  = $signed({1'b0, rr_reg}) - $signed({1'b0, rl_reg});
        diff_side  = $signed({1'b0, sr_reg}) - $signed({1'b0, sl_reg});
        diff_fb    = $signed({2'b00, fl_reg}) + $signed({2'b00, fr_reg})
                   - $signed({2'b00, rl_reg}) - $signed({2'b00, rr_reg});
        rear_prod  = diff_rear * $signed({1'b0, sped_pkg::REAR_WEIGHT});
        mix_d      = '0;
        mix_e      = '0;
        if (count_reg >= sped_pkg::LAYOUT_STEREO)
        begin
            mix_d = sped_pkg::MIX_W'(diff_front) <<< sped_pkg::UNIT_SHIFT;
        end
        if (count_reg >= sped_pkg::LAYOUT_5_1)
        begin
            mix_d = mix_d + sped_pkg::MIX_W'(rear_prod);
            mix_e = 32'(diff_fb) <<< sped_pkg::UNIT_SHIFT;
        end
        if (count_reg >= sped_pkg::LAYOUT_7_1)
        begin
            mix_d = mix_d + (sped_pkg::MIX_W'(diff_side) <<< sped_pkg::UNIT_SHIFT);
        end
    end

    // Serial gain multiply, most significant gain bit first.
    always_comb
    begin
        x_acc_next = x_acc_reg <<< 1;
        y_acc_next = y_acc_reg <<< 1;
        if (gain_reg[step_reg])
        begin
            x_acc_next = x_acc_next + sped_pkg::PROD_W'(d_reg);
            y_acc_next = y_acc_next + sped_pkg::PROD_W'(e_reg);
        end
        abs_x = sped_pkg::ABS_W'(x_acc_reg[sped_pkg::PROD_W-1] ? -x_acc_reg : x_acc_reg);
        abs_y = sped_pkg::ABS_W'(y_acc_reg[sped_pkg::PROD_W-1] ? -y_acc_reg : y_acc_reg);
    end

    // Restoring division step for both components against the common maximum.
    always_comb
    begin
        shift_x = (step_reg == '0) ? rem_x_reg : (rem_x_reg << 1);
        shift_y = (step_reg == '0) ? rem_y_reg : (rem_y_reg << 1);
        ge_x    = shift_x >= {1'b0, max_reg};
        ge_y    = shift_y >= {1'b0, max_reg};
    end

    // Unit-range components with their sign restored.
    always_comb
    begin
        small_x = abs_x_reg >> sped_pkg::MIX_SHIFT;
        small_y = abs_y_reg >> sped_pkg::MIX_SHIFT;
        if (big_reg)
        begin
            unit_x = q_x_reg;
            unit_y = q_y_reg;
        end
        else
        begin
            unit_x = (small_x > sped_pkg::ABS_W'(sped_pkg::UNIT_ONE))
                   ? sped_pkg::UNIT_ONE : small_x[sped_pkg::QUO_W-1:0];
            unit_y = (small_y > sped_pkg::ABS_W'(sped_pkg::UNIT_ONE))
                   ? sped_pkg::UNIT_ONE : small_y[sped_pkg::QUO_W-1:0];
        end
        nx = neg_x_reg ? -$signed({1'b0, unit_x}) : $signed({1'b0, unit_x});
        ny = neg_y_reg ? -$signed({1'b0, unit_y}) : $signed({1'b0, unit_y});
        sum_x_next = sum_x_reg + sped_pkg::SUM_W'(nx)
                   - sped_pkg::SUM_W'(ring_x_reg[slot_reg]);
        sum_y_next = sum_y_reg + sped_pkg::SUM_W'(ny)
                   - sped_pkg::SUM_W'(ring_y_reg[slot_reg]);
    end

    // Window mean truncated toward zero.
    always_comb
    begin
        bias_x = sum_x_reg + (sum_x_reg[sped_pkg::SUM_W-1]
               ? sped_pkg::SUM_W'(sped_pkg::WINDOW_LEN - 1) : '0);
        bias_y = sum_y_reg + (sum_y_reg[sped_pkg::SUM_W-1]
               ? sped_pkg::SUM_W'(sped_pkg::WINDOW_LEN - 1) : '0);
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= sped_pkg::GAIN_RESET;
            count_reg <= sped_pkg::COUNT_RESET;
            thr_reg   <= sped_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sped_pkg::CFG_GAIN:      gain_reg  <= cfg_data;
                sped_pkg::CFG_COUNT:     count_reg <= cfg_data[sped_pkg::CNT_W-1:0];
                sped_pkg::CFG_THRESHOLD: thr_reg   <= cfg_data[sped_pkg::THR_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Main sequencer with the datapath and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fl_reg          <= '0;
            fr_reg          <= '0;
            rl_reg          <= '0;
            rr_reg          <= '0;
            sl_reg          <= '0;
            sr_reg          <= '0;
            d_reg           <= '0;
            e_reg           <= '0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            step_reg        <= '0;
            abs_x_reg       <= '0;
            abs_y_reg       <= '0;
            max_reg         <= '0;
            big_reg         <= 1'b0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            rem_x_reg       <= '0;
            rem_y_reg       <= '0;
            q_x_reg         <= '0;
            q_y_reg         <= '0;
            for (int i = 0; i < sped_pkg::WINDOW_LEN; i++)
            begin
                ring_x_reg[i] <= '0;
                ring_y_reg[i] <= '0;
            end
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            slot_reg        <= '0;
            avg_x_reg       <= '0;
            avg_y_reg       <= '0;
            start_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_mag_reg     <= '0;
            out_bearing_reg <= '0;
            out_above_reg   <= 1'b0;
        end
        else
        begin
            start_reg     <= (state_reg == ST_AVG);
            // A new result loads when free; a waiting result stays while stalled.
            out_valid_reg <= ((state_reg == ST_DONE) && out_free)
                          || (out_valid_reg && out_stall);
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        fl_reg    <= front_left;
                        fr_reg    <= front_right;
                        rl_reg    <= rear_left;
                        rr_reg    <= rear_right;
                        sl_reg    <= side_left;
                        sr_reg    <= side_right;
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX:
                begin
                    d_reg     <= mix_d;
                    e_reg     <= mix_e;
                    x_acc_reg <= '0;
                    y_acc_reg <= '0;
                    step_reg  <= 4'd15;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    x_acc_reg <= x_acc_next;
                    y_acc_reg <= y_acc_next;
                    step_reg  <= step_reg - 4'd1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    abs_x_reg <= abs_x;
                    abs_y_reg <= abs_y;
                    max_reg   <= (abs_y > abs_x) ? abs_y : abs_x;
                    big_reg   <= ((abs_y > abs_x) ? abs_y : abs_x) > sped_pkg::BIG_LIMIT;
                    neg_x_reg <= x_acc_reg[sped_pkg::PROD_W-1];
                    neg_y_reg <= y_acc_reg[sped_pkg::PROD_W-1];
                    rem_x_reg <= {1'b0, abs_x};
                    rem_y_reg <= {1'b0, abs_y};
                    step_reg  <= '0;
                    if (((abs_y > abs_x) ? abs_y : abs_x) > sped_pkg::BIG_LIMIT)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_RING;
                    end
                end
                ST_DIV:
                begin
                    rem_x_reg <= ge_x ? shift_x - {1'b0, max_reg} : shift_x;
                    rem_y_reg <= ge_y ? shift_y - {1'b0, max_reg} : shift_y;
                    q_x_reg   <= {q_x_reg[sped_pkg::QUO_W-2:0], ge_x};
                    q_y_reg   <= {q_y_reg[sped_pkg::QUO_W-2:0], ge_y};
                    step_reg  <= step_reg + 4'd1;
                    if (step_reg == 4'd14)
                    begin
                        state_reg <= ST_RING;
                    end
                end
                ST_RING:
                begin
                    sum_x_reg            <= sum_x_next;
                    sum_y_reg            <= sum_y_next;
                    ring_x_reg[slot_reg] <= nx;
                    ring_y_reg[slot_reg] <= ny;
                    slot_reg <= (slot_reg == sped_pkg::WIN_BITS'(sped_pkg::WINDOW_LEN - 1))
                              ? '0 : slot_reg + 1'b1;
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    avg_x_reg <= sped_pkg::UNIT_W'(bias_x >>> sped_pkg::WIN_BITS);
                    avg_y_reg <= sped_pkg::UNIT_W'(bias_y >>> sped_pkg::WIN_BITS);
                    state_reg <= ST_POLAR;
                end
                ST_POLAR:
                begin
                    if (polar_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_x_reg       <= avg_x_reg;
                        out_y_reg       <= avg_y_reg;
                        out_mag_reg     <= polar_mag;
                        out_bearing_reg <= polar_bearing;
                        out_above_reg   <= polar_mag > thr_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Magnitude and bearing of the averaged vector.
    sped_polar u_polar
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .avg_x     (avg_x_reg),
        .avg_y     (avg_y_reg),
        .done      (polar_done),
        .magnitude (polar_mag),
        .bearing   (polar_bearing)
    );

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign avg_x           = out_x_reg;
    assign avg_y           = out_y_reg;
    assign magnitude       = out_mag_reg;
    assign bearing         = out_bearing_reg;
    assign above_threshold = out_above_reg;

    // The flag must agree with the reported magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_above_reg == (out_mag_reg > thr_reg)))
        else $error("threshold flag disagrees with magnitude");

    // Averages stay within the unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_x_reg >= -16'sd16384) && (out_x_reg <= 16'sd16384)
                        && (out_y_reg >= -16'sd16384) && (out_y_reg <= 16'sd16384)))
        else $error("average out of unit range");

    // The polar unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        polar_done |-> (state_reg == ST_POLAR))
        else $error("polar unit finished outside its window");

    // An accepted transaction starts the mix step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MIX))
        else $error("accepted item did not start processing");

endmodule
